// File: rtl/core/sirc_pkg.sv
// Shared types, constants and helpers for the signed integer to radix text unit.
package sirc_pkg;

  localparam int unsigned NumW      = 32;
  localparam int unsigned MaxRadix  = 16;
  localparam int unsigned MaxDigits = 32;
  localparam int unsigned DigitW    = $clog2(MaxRadix);
  localparam int unsigned DigIdxW   = $clog2(MaxDigits);
  localparam int unsigned DigCntW   = DigIdxW + 1;
  localparam int unsigned BitCntW   = $clog2(NumW);
  localparam int unsigned BaseW     = 5;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [7:0] MinusChar = 8'h2D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] NulChar   = 8'h00;

  localparam logic [CfgIdxW-1:0] RegBaseSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAlphaLow = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAlphaHi  = 2'd2;

  localparam logic [BaseW-1:0] BaseSizeRst = 5'd10;
  localparam logic [CfgW-1:0]  AlphaLowRst = 64'h3736353433323130;
  localparam logic [CfgW-1:0]  AlphaHiRst  = 64'h6665646362613938;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } sirc_state_t;

  // Character at alphabet position idx.
  function automatic logic [7:0] alpha_char(input logic [DigitW-1:0] idx,
                                            input logic [CfgW-1:0] lo,
                                            input logic [CfgW-1:0] hi);
    logic [2*CfgW-1:0] full;
    full = {hi, lo};
    return full[{idx, 3'b000} +: 8];
  endfunction

  // Alphabet check: radix in range, no NUL/sign characters, no duplicates.
  function automatic logic alphabet_ok(input logic [BaseW-1:0] n,
                                       input logic [CfgW-1:0] lo,
                                       input logic [CfgW-1:0] hi);
    logic ok;
    logic [7:0] ci;
    ok = (n >= BaseW'(2)) && (n <= BaseW'(MaxRadix));
    for (int i = 0; i < MaxRadix; i++) begin
      ci = alpha_char(DigitW'(i), lo, hi);
      if (BaseW'(i) < n) begin
        if (ci == NulChar || ci == PlusChar || ci == MinusChar) ok = 1'b0;
        for (int j = i + 1; j < MaxRadix; j++) begin
          if (BaseW'(j) < n && alpha_char(DigitW'(j), lo, hi) == ci) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

// File: rtl/core/signed_int_to_radix_chars_unit.sv
// Top level: signed 32-bit integer to text in a configurable radix, bit-serial divider.
// Operation: each digit comes from a bit-serial division of the running quotient; up to
//   32 digits, then the output characters (sign, digits) one at a time, most significant first.
// Flow: one number at a time; a new number is taken only once the last character of the
//   previous result, or its error result, has been loaded into the output register.
// Reset (rst_n, synchronous, active low) clears control state and restores the
//   configuration to radix 10 with alphabet "0123456789abcdef".
module signed_int_to_radix_chars_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [sirc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sirc_pkg::CfgW-1:0]     cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [sirc_pkg::NumW-1:0] in_number,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_character,
  output logic                          out_last_char,
  output logic                          out_bad_base
);
  import sirc_pkg::*;

  // Configuration registers.
  logic [BaseW-1:0] base_size_r;
  logic [CfgW-1:0]  alpha_low_r;
  logic [CfgW-1:0]  alpha_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r  <= BaseSizeRst;
      alpha_low_r  <= AlphaLowRst;
      alpha_high_r <= AlphaHiRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegBaseSize: base_size_r  <= cfg_wdata[BaseW-1:0];
        RegAlphaLow: alpha_low_r  <= cfg_wdata;
        RegAlphaHi:  alpha_high_r <= cfg_wdata;
        default:     ;  // unmapped index, write dropped
      endcase
    end
  end

  // User must keep config static while a number is in flight (not enforced); check sampled at transfer.
  logic base_ok;
  assign base_ok = alphabet_ok(base_size_r, alpha_low_r, alpha_high_r);

  // Control and datapath state.
  sirc_state_t          state_r, state_nxt;
  logic                 neg_r, neg_nxt;
  logic [NumW-1:0]      quo_r, quo_nxt;      // dividend shifts out, quotient shifts in
  logic [DigitW-1:0]    rem_r, rem_nxt;      // partial remainder, always below radix
  logic                 qnz_r, qnz_nxt;      // quotient has a set bit so far
  logic [BitCntW-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DigCntW-1:0]   dig_cnt_r, dig_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_bad_r, out_bad_nxt;

  // Digit store: no reset, each entry written before it is read.
  logic [DigitW-1:0]    digit_store [MaxDigits];
  logic                 dig_we;

  // Output slot free when empty or its transfer completes this cycle.
  logic slot_free;
  assign slot_free = !out_valid_r || out_ready;

  logic in_xfer;
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // One restoring division step per cycle.
  logic [DigitW:0] trial;
  logic            q_bit;
  logic [DigitW:0] trial_sub;
  logic            last_bit;
  assign trial     = {rem_r, quo_r[NumW-1]};
  assign q_bit     = (trial >= base_size_r);
  assign trial_sub = q_bit ? (trial - base_size_r) : trial;
  assign last_bit  = (bit_cnt_r == BitCntW'(NumW - 1));

  // Digit read for emission, most significant first.
  logic [DigIdxW-1:0] rd_idx;
  logic [DigitW-1:0]  rd_digit;
  assign rd_idx   = DigIdxW'(dig_cnt_r - DigCntW'(1));
  assign rd_digit = digit_store[rd_idx];

  // Magnitude of the input: two's complement negate, fits 32 bits unsigned.
  logic [NumW-1:0] in_mag;
  assign in_mag = in_number[NumW-1] ? (~in_number + NumW'(1)) : in_number;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = base_ok ? ST_DIV : ST_ERR;
      ST_DIV:  if (last_bit && !(qnz_r || q_bit))
                 state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      ST_SIGN: if (slot_free) state_nxt = ST_EMIT;
      ST_EMIT: if (slot_free && dig_cnt_r == DigCntW'(1)) state_nxt = ST_IDLE;
      ST_ERR:  if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    qnz_nxt       = qnz_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    dig_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt     = in_number[NumW-1];
          quo_nxt     = in_mag;
          rem_nxt     = '0;
          qnz_nxt     = 1'b0;
          bit_cnt_nxt = '0;
          dig_cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        quo_nxt     = {quo_r[NumW-2:0], q_bit};
        rem_nxt     = trial_sub[DigitW-1:0];
        qnz_nxt     = qnz_r || q_bit;
        bit_cnt_nxt = bit_cnt_r + BitCntW'(1);
        if (last_bit) begin
          // digit done: store it and restart on the quotient
          dig_we      = 1'b1;
          dig_cnt_nxt = dig_cnt_r + DigCntW'(1);
          rem_nxt     = '0;
          qnz_nxt     = 1'b0;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = MinusChar;
          out_last_nxt  = 1'b0;
          out_bad_nxt   = 1'b0;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = alpha_char(rd_digit, alpha_low_r, alpha_high_r);
          out_last_nxt  = (dig_cnt_r == DigCntW'(1));
          out_bad_nxt   = 1'b0;
          dig_cnt_nxt   = dig_cnt_r - DigCntW'(1);
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = NulChar;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dig_cnt_r   <= '0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    qnz_r      <= qnz_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
    if (dig_we) digit_store[dig_cnt_r[DigIdxW-1:0]] <= trial_sub[DigitW-1:0];
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;
  assign out_bad_base  = out_bad_r;

endmodule
